// File: rtl/catan_pkg.sv
`default_nettype none
package catan_pkg;

    // Number of CORDIC rotations, one pipeline stage each (range 8 to 64).
    localparam int ITERATIONS = 50;
    localparam int IDX_W      = 6;
    localparam int Z_W        = 67;

    typedef logic [IDX_W-1:0] t_idx;

    localparam logic [63:0] PI_FRAC      = 64'h243F6A8885A308D3;
    localparam logic [63:0] HALF_PI_FRAC = 64'h921FB54442D18469;

    // Angle constants, kept to the low 3 integer bits plus the fraction word.
    localparam logic [Z_W-1:0] PI_Z       = {3'd3, PI_FRAC};
    localparam logic [Z_W-1:0] HALF_PI_Z  = {3'd1, HALF_PI_FRAC};
    localparam logic [Z_W-1:0] NHALF_PI_Z = Z_W'(0) - HALF_PI_Z;

    // How the output stage forms the angle.
    localparam logic [2:0] CODE_ZERO   = 3'd0;
    localparam logic [2:0] CODE_HPI_P  = 3'd1;
    localparam logic [2:0] CODE_HPI_N  = 3'd2;
    localparam logic [2:0] CODE_PI     = 3'd3;
    localparam logic [2:0] CODE_CORDIC = 3'd4;

    typedef struct packed {
        logic signed [63:0] y_int;
        logic [63:0]        y_frac;
        logic signed [63:0] x_int;
        logic [63:0]        x_frac;
    } t_req;

    typedef struct packed {
        logic signed [2:0] angle_int;
        logic [63:0]       angle_frac;
    } t_res;

    // Quadrant and special-case information that rides along the pipeline.
    typedef struct packed {
        logic       xneg;
        logic       yneg;
        logic [2:0] code;
    } t_tag;

    typedef struct packed {
        logic [127:0]   cx;
        logic [127:0]   cy;
        logic [Z_W-1:0] z;
        t_tag           tag;
    } t_cord;

    // Arctangent ROM: floor(atan(2^-i) * 2^64).
    function automatic logic [63:0] atan_angle(input t_idx i);
        logic [63:0] v;
        case (i)
            6'd0:    v = 64'hC90FDAA22168C234;
            6'd1:    v = 64'h76B19C1586ED3DA2;
            6'd2:    v = 64'h3EB6EBF259F05DE9;
            6'd3:    v = 64'h1FD5BA9AAC2F6DC6;
            6'd4:    v = 64'h0FFAADDB967EF4E3;
            6'd5:    v = 64'h07FF556EED4B9EFA;
            6'd6:    v = 64'h03FFEAAB776E5395;
            6'd7:    v = 64'h01FFFD555BAAB6CE;
            6'd8:    v = 64'h00FFFFAAAADDDDB9;
            6'd9:    v = 64'h007FFFF55556EEEE;
            6'd10:   v = 64'h003FFFFEAAAAB777;
            6'd11:   v = 64'h001FFFFFD55555BB;
            6'd12:   v = 64'h000FFFFFFAAAAAAD;
            6'd13:   v = 64'h0007FFFFFF555555;
            6'd14:   v = 64'h0003FFFFFFEAAAAA;
            6'd15:   v = 64'h0001FFFFFFFD5555;
            6'd16:   v = 64'h0000FFFFFFFFAAAA;
            6'd17:   v = 64'h00007FFFFFFFF555;
            6'd18:   v = 64'h00003FFFFFFFFEAA;
            6'd19:   v = 64'h00001FFFFFFFFFD5;
            6'd20:   v = 64'h00000FFFFFFFFFFA;
            6'd21:   v = 64'h000007FFFFFFFFFF;
            // Past this point atan(2^-i) rounds down to 2^(64-i) - 1.
            default: v = 64'hFFFFFFFFFFFFFFFF >> i;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/catan_prep.sv
`default_nettype none
module catan_prep (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire catan_pkg::t_req  i_req,
    output logic                  o_valid,
    output catan_pkg::t_cord      o_cord
);

    logic [127:0]     w_x;
    logic [127:0]     w_y;
    logic             w_xz;
    logic             w_yz;
    catan_pkg::t_cord n_cord;
    catan_pkg::t_cord r_cord;
    logic             r_valid;

    assign w_x  = {i_req.x_int, i_req.x_frac};
    assign w_y  = {i_req.y_int, i_req.y_frac};
    assign w_xz = (w_x == 128'd0);
    assign w_yz = (w_y == 128'd0);

    // Classify the point and take magnitudes of both coordinates.
    always_comb begin
        n_cord.tag.xneg = w_x[127];
        n_cord.tag.yneg = w_y[127];
        n_cord.cx       = w_x[127] ? (128'd0 - w_x) : w_x;
        n_cord.cy       = w_y[127] ? (128'd0 - w_y) : w_y;
        n_cord.z        = '0;
        if (w_xz && w_yz) begin
            n_cord.tag.code = catan_pkg::CODE_ZERO;
        end else if (w_xz) begin
            n_cord.tag.code = w_y[127] ? catan_pkg::CODE_HPI_N : catan_pkg::CODE_HPI_P;
        end else if (w_yz) begin
            n_cord.tag.code = w_x[127] ? catan_pkg::CODE_PI : catan_pkg::CODE_ZERO;
        end else begin
            n_cord.tag.code = catan_pkg::CODE_CORDIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cord <= n_cord;
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;

endmodule
`default_nettype wire

// File: rtl/catan_iter.sv
`default_nettype none
module catan_iter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire catan_pkg::t_idx   i_idx,
    input  wire logic              i_valid,
    input  wire catan_pkg::t_cord  i_cord,
    output logic                   o_valid,
    output catan_pkg::t_cord       o_cord
);

    logic [127:0]                w_xs;
    logic [127:0]                w_ys;
    logic [catan_pkg::Z_W-1:0]   w_ang;
    logic                        w_up;
    catan_pkg::t_cord            n_cord;
    catan_pkg::t_cord            r_cord;
    logic                        r_valid;

    // The stage index is tied to a constant, so the shifts reduce to wiring.
    assign w_xs  = 128'($signed(i_cord.cx) >>> i_idx);
    assign w_ys  = 128'($signed(i_cord.cy) >>> i_idx);
    assign w_ang = catan_pkg::Z_W'(catan_pkg::atan_angle(i_idx));
    assign w_up  = ~i_cord.cy[127];

    // One vectoring rotation: drive y toward zero and accumulate the angle.
    always_comb begin
        n_cord.tag = i_cord.tag;
        if (w_up) begin
            n_cord.cx = i_cord.cx + w_ys;
            n_cord.cy = i_cord.cy - w_xs;
            n_cord.z  = i_cord.z + w_ang;
        end else begin
            n_cord.cx = i_cord.cx - w_ys;
            n_cord.cy = i_cord.cy + w_xs;
            n_cord.z  = i_cord.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cord <= n_cord;
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;

endmodule
`default_nettype wire

// File: rtl/catan_post.sv
`default_nettype none
module catan_post (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire catan_pkg::t_cord  i_cord,
    output logic                   o_valid,
    output catan_pkg::t_res        o_res
);

    logic [catan_pkg::Z_W-1:0] w_base;
    logic [catan_pkg::Z_W-1:0] n_z;
    logic                      r_valid;
    catan_pkg::t_res           r_res;

    assign w_base = i_cord.tag.xneg ? catan_pkg::PI_Z : '0;

    // Quadrant fix: pi - z for negative x, then negate for negative y.
    // Both steps fold into one subtract whose order depends on the signs.
    always_comb begin
        case (i_cord.tag.code)
            catan_pkg::CODE_HPI_P:  n_z = catan_pkg::HALF_PI_Z;
            catan_pkg::CODE_HPI_N:  n_z = catan_pkg::NHALF_PI_Z;
            catan_pkg::CODE_PI:     n_z = catan_pkg::PI_Z;
            catan_pkg::CODE_CORDIC: begin
                if (i_cord.tag.xneg ^ i_cord.tag.yneg) begin
                    n_z = w_base - i_cord.z;
                end else begin
                    n_z = i_cord.z - w_base;
                end
            end
            default:                n_z = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.angle_int  <= n_z[66:64];
        r_res.angle_frac <= n_z[63:0];
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// File: rtl/cordic_atan2_q64_top.sv
`default_nettype none
// Four-quadrant arctangent of a Q64.64 point (y, x), result in Q3.64 radians.
// Request channel: drive i_req with the point and raise start; the request is
// taken at a rising edge where start is high and busy is low.
// Result channel: o_done is high for exactly one cycle while o_res holds the
// angle; the receiver must take it in that cycle.
// Pipeline: a first stage classifies the point and takes magnitudes, the
// CORDIC rotation stages follow, and a last stage applies the quadrant
// correction.
// Throughput: one request per cycle while busy is low. Each rotation has its
// own stage with one pair of 128-bit adders, so requests overlap freely.
// Results come out in request order.
// Reset: a synchronous active-low reset clears every valid bit in the pipeline
// and holds busy high until the cycle after reset is released.
// The receiver cannot stall, so the pipeline never holds a result back.
module cordic_atan2_q64_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire catan_pkg::t_req  i_req,
    output logic                  o_done,
    output catan_pkg::t_res       o_res
);

    logic             r_run;
    logic             w_valid [0:catan_pkg::ITERATIONS];
    catan_pkg::t_cord w_cord  [0:catan_pkg::ITERATIONS];

    // Ready once out of reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = ~r_run;

    catan_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & r_run),
        .i_req   (i_req),
        .o_valid (w_valid[0]),
        .o_cord  (w_cord[0])
    );

    // One rotation stage per iteration.
    for (genvar g = 0; g < catan_pkg::ITERATIONS; g++) begin : g_iter
        catan_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (catan_pkg::t_idx'(g)),
            .i_valid (w_valid[g]),
            .i_cord  (w_cord[g]),
            .o_valid (w_valid[g+1]),
            .o_cord  (w_cord[g+1])
        );
    end

    catan_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[catan_pkg::ITERATIONS]),
        .i_cord  (w_cord[catan_pkg::ITERATIONS]),
        .o_valid (o_done),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// File: dv/tb_cordic_atan2_q64_top.sv
`timescale 1ns / 100ps
module tb_cordic_atan2_q64_top;
    import catan_pkg::*;

    // Pipeline length: the prep register, one register per rotation and the post register.
    localparam int LATENCY = ITERATIONS + 2;

    localparam logic [127:0] MAX_COORD = {1'b0, {127{1'b1}}};
    localparam logic [127:0] MIN_COORD = {1'b1, 127'd0};
    localparam logic [127:0] ONE_COORD = 128'd1 << 64;
    localparam logic [127:0] ULP_COORD = 128'd1;
    localparam logic [127:0] PI_COORD  = {64'd3, 64'h243F6A8885A308D3};
    localparam logic [127:0] HPI_COORD = {64'd1, 64'h921FB54442D18469};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    t_req i_req;
    t_res o_res;

    t_res expected_angles[$];
    int   n_errors;
    int   n_points;
    int   n_angles;
    int   gap_pct;

    cordic_atan2_q64_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // Free-running clock with an 8 ns period.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs or drops results.
    initial begin
        #4_000_000;
        $display("tb_cordic_atan2_q64_top: FAIL");
        $finish;
    end

    // Arctangent of 2^-i in 2^-64 units, rounded down.
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] a;
        case (i)
            0:  a = 64'hC90FDAA22168C234;
            1:  a = 64'h76B19C1586ED3DA2;
            2:  a = 64'h3EB6EBF259F05DE9;
            3:  a = 64'h1FD5BA9AAC2F6DC6;
            4:  a = 64'h0FFAADDB967EF4E3;
            5:  a = 64'h07FF556EED4B9EFA;
            6:  a = 64'h03FFEAAB776E5395;
            7:  a = 64'h01FFFD555BAAB6CE;
            8:  a = 64'h00FFFFAAAADDDDB9;
            9:  a = 64'h007FFFF55556EEEE;
            10: a = 64'h003FFFFEAAAAB777;
            11: a = 64'h001FFFFFD55555BB;
            12: a = 64'h000FFFFFFAAAAAAD;
            13: a = 64'h0007FFFFFF555555;
            14: a = 64'h0003FFFFFFEAAAAA;
            15: a = 64'h0001FFFFFFFD5555;
            16: a = 64'h0000FFFFFFFFAAAA;
            17: a = 64'h00007FFFFFFFF555;
            18: a = 64'h00003FFFFFFFFEAA;
            19: a = 64'h00001FFFFFFFFFD5;
            20: a = 64'h00000FFFFFFFFFFA;
            21: a = 64'h000007FFFFFFFFFF;
            default: begin
                // Beyond this the angle equals the shift weight minus one ulp.
                if (i < 64) a = (64'd1 << (64 - i)) - 64'd1;
                else        a = 64'd0;
            end
        endcase
        return a;
    endfunction

    // Expected angle of a point, with all 128-bit arithmetic wrapping.
    function automatic t_res atan2_of_point(input t_req p);
        logic [127:0] y, x, cx, cy, xs, ys, z, step;
        t_res         r;
        int           i;
        y = {p.y_int, p.y_frac};
        x = {p.x_int, p.x_frac};
        if (x == 128'd0 && y == 128'd0) begin
            z = 128'd0;
        end else if (x == 128'd0) begin
            z = y[127] ? -HPI_COORD : HPI_COORD;
        end else if (y == 128'd0) begin
            z = x[127] ? PI_COORD : 128'd0;
        end else begin
            // Vectoring on the magnitudes drives cy toward zero.
            cx = x[127] ? -x : x;
            cy = y[127] ? -y : y;
            z  = 128'd0;
            for (i = 0; i < ITERATIONS; i++) begin
                xs   = $signed(cx) >>> i;
                ys   = $signed(cy) >>> i;
                step = {64'd0, atan_pow2(i)};
                if (!cy[127]) begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z  = z + step;
                end else begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z  = z - step;
                end
            end
            // Fold the first-quadrant angle back into the point's quadrant.
            if (x[127]) z = PI_COORD - z;
            if (y[127]) z = -z;
        end
        r.angle_int  = z[66:64];
        r.angle_frac = z[63:0];
        return r;
    endfunction

    // Random coordinate: mostly in the useful range, some raw words that wrap, some zero or with no fraction.
    function automatic logic [127:0] random_coord();
        logic [127:0] v;
        int unsigned  kind;
        v    = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(9);
        if (kind >= 3 && kind <= 7) begin
            v = $signed(v) >>> $urandom_range(127, 65);
        end else if (kind == 8) begin
            v = 128'd0;
        end else if (kind == 9) begin
            v[63:0] = 64'd0;
        end
        return v;
    endfunction

    // Sends one request after an optional random gap and records its angle.
    task automatic send_point(input logic [127:0] y, input logic [127:0] x);
        t_req p;
        int   gap;
        p.y_int  = y[127:64];
        p.y_frac = y[63:0];
        p.x_int  = x[127:64];
        p.x_frac = x[63:0];
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 20) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_angles.push_back(atan2_of_point(p));
        n_points++;
    endtask

    // Stops sending and waits until every pending angle has come back.
    task automatic wait_for_angles();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_angles.size() != 0) @(posedge i_clk);
    endtask

    // Origin and points on the axes, answered without rotation.
    task automatic test_origin_and_axes();
        send_point(128'd0, 128'd0);
        send_point(ONE_COORD, 128'd0);
        send_point(-ONE_COORD, 128'd0);
        send_point(ULP_COORD, 128'd0);
        send_point(-ULP_COORD, 128'd0);
        send_point(MIN_COORD, 128'd0);
        send_point(128'd0, ONE_COORD);
        send_point(128'd0, -ULP_COORD);
        send_point(128'd0, MIN_COORD);
    endtask

    // Field extremes, diagonals in every quadrant and wrapped magnitudes.
    task automatic test_extremes();
        send_point(ONE_COORD, ONE_COORD);
        send_point(ONE_COORD, -ONE_COORD);
        send_point(-ONE_COORD, ONE_COORD);
        send_point(-ONE_COORD, -ONE_COORD);
        send_point(MAX_COORD, MAX_COORD);
        send_point(MIN_COORD, MIN_COORD);
        send_point(MAX_COORD, MIN_COORD);
        send_point(MIN_COORD, MAX_COORD);
        send_point(ULP_COORD, ULP_COORD);
        send_point(ULP_COORD, MAX_COORD);
        send_point(MAX_COORD, ULP_COORD);
        send_point(128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF,
                   128'hFFFF_FFFF_FFFF_FFFF_0000_0000_0000_0001);
        send_point(128'd1 << 125, -(128'd1 << 125));
    endtask

    // Random points, with one full drain halfway through.
    task automatic test_random_points(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_point(random_coord(), random_coord());
            if (k == count / 2) wait_for_angles();
        end
    endtask

    // Compares each result with the oldest pending angle.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (expected_angles.size() == 0) begin
                $display("%0t: angle with no request pending: int %0d frac %h",
                         $time, o_res.angle_int, o_res.angle_frac);
                n_errors++;
            end else begin
                want = expected_angles.pop_front();
                n_angles++;
                if (o_res.angle_int !== want.angle_int) begin
                    $display("%0t: angle_int expected %0d actual %0d",
                             $time, want.angle_int, o_res.angle_int);
                    n_errors++;
                end
                if (o_res.angle_frac !== want.angle_frac) begin
                    $display("%0t: angle_frac expected %h actual %h",
                             $time, want.angle_frac, o_res.angle_frac);
                    n_errors++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        n_errors = 0;
        n_points = 0;
        n_angles = 0;
        gap_pct  = 30;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_origin_and_axes();
        test_extremes();
        test_random_points(400);
        wait_for_angles();
        gap_pct = 66;
        test_random_points(400);
        wait_for_angles();
        gap_pct = 0;
        test_random_points(350);
        wait_for_angles();
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Checked %0d angles from %0d points: origin, axes, all quadrants,",
                 n_angles, n_points);
        $display("field extremes and wrapped magnitudes, sender gaps heavy, light and none.");
        if (n_errors == 0 && expected_angles.size() == 0) begin
            $display("tb_cordic_atan2_q64_top: PASS");
        end else begin
            $display("tb_cordic_atan2_q64_top: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/catan_pkg.sv
rtl/catan_prep.sv
rtl/catan_iter.sv
rtl/catan_post.sv
rtl/cordic_atan2_q64_top.sv
dv/tb_cordic_atan2_q64_top.sv
